### hw/rtl/pwtw_pkg.sv
// shared types and constants for the piecewise linear time warp
package pwtw_pkg;

	localparam int TIME_W = 32;
	localparam int SEG_W  = 33;
	localparam int MAG_W  = 34;
	localparam int PROD_W = 68;
	localparam int QBITS  = 36;
	localparam int SUM_W  = 38;
	localparam int SC_W   = 31;
	localparam int VEL_W  = 5;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_BLANK    = 3'd0,
		REG_CONSONANT_LEN = 3'd1,
		REG_RIGHT_BLANK   = 3'd2,
		REG_REQUIRED_LEN  = 3'd3,
		REG_NOTE_VELOCITY = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] lead_gap;
		logic signed [TIME_W-1:0] cons_len;
		logic signed [TIME_W-1:0] tail_gap;
		logic signed [TIME_W-1:0] note_len;
		logic        [SC_W-1:0]   stretched;
	} cfg_t;

	typedef struct packed {
		logic        [MAG_W-1:0] rem;
		logic        [QBITS-1:0] pbits;
		logic        [QBITS-1:0] quo;
		logic        [MAG_W-1:0] dvs;
		logic signed [MAG_W-1:0] base;
		logic                    neg;
		logic                    ovf;
		logic                    mid;
	} cell_t;

endpackage

### hw/rtl/pwtw_cfg.sv
// configuration registers and stretched consonant length
module pwtw_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [pwtw_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pwtw_pkg::TIME_W-1:0]  cfg_data,
	output pwtw_pkg::cfg_t               cfg
);
	import pwtw_pkg::*;

	logic signed [TIME_W-1:0] lb_q, cl_q, rb_q, rl_q;
	logic        [VEL_W-1:0]  vel_q;
	logic        [SC_W-1:0]   sc_q;
	logic        [4:0]        amt;
	logic        [47:0]       wide_c;
	logic        [47:0]       shifted;
	logic        [SC_W-1:0]   sc_next;

	// shift right by 16 + velocity from a value pre-shifted left by 17
	assign amt     = {~vel_q[4], vel_q[3:0]};
	assign wide_c  = {cl_q[30:0], 17'd0};
	assign shifted = wide_c >> amt;

	always_comb begin
		if (cl_q[TIME_W-1] || cl_q == '0) begin
			sc_next = '0;
		end else if (|shifted[47:31]) begin
			sc_next = '1;
		end else begin
			sc_next = shifted[SC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q  <= '0;
			cl_q  <= '0;
			rb_q  <= '0;
			rl_q  <= '0;
			vel_q <= VEL_W'(1);
			sc_q  <= '0;
		end else begin
			sc_q <= sc_next;
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_LEFT_BLANK:    lb_q  <= cfg_data;
					REG_CONSONANT_LEN: cl_q  <= cfg_data;
					REG_RIGHT_BLANK:   rb_q  <= cfg_data;
					REG_REQUIRED_LEN:  rl_q  <= cfg_data;
					REG_NOTE_VELOCITY: vel_q <= cfg_data[VEL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.lead_gap  = lb_q;
	assign cfg.cons_len  = cl_q;
	assign cfg.tail_gap  = rb_q;
	assign cfg.note_len  = rl_q;
	assign cfg.stretched = sc_q;

	a_sc_needs_positive: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q != '0 |-> ($past(cl_q[TIME_W-1]) == 1'b0 && $past(cl_q) != '0))
		else $error("stretch nonzero for nonpositive consonant");
	a_vel_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_NOTE_VELOCITY |=> vel_q == $past(cfg_data[VEL_W-1:0]))
		else $error("velocity write lost");
	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index > REG_NOTE_VELOCITY |=> $stable(lb_q) && $stable(cl_q)
			&& $stable(rb_q) && $stable(rl_q) && $stable(vel_q))
		else $error("write beyond register list changed state");

endmodule

### hw/rtl/pwtw_cell.sv
// one restoring divider cell: one quotient bit per stage
module pwtw_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  pwtw_pkg::cell_t d,
	output logic            valid_out,
	output pwtw_pkg::cell_t q
);
	import pwtw_pkg::*;

	logic          vld_q;
	cell_t         c_q;
	cell_t         nxt;
	logic [MAG_W:0] trial;
	logic           take;

	always_comb begin
		trial = {d.rem, d.pbits[QBITS-1]};
		take  = trial >= {1'b0, d.dvs};
		nxt       = d;
		nxt.pbits = {d.pbits[QBITS-2:0], 1'b0};
		nxt.quo   = {d.quo[QBITS-2:0], take};
		if (take) begin
			nxt.rem = MAG_W'(trial - {1'b0, d.dvs});
		end else begin
			nxt.rem = trial[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= nxt;
		end
	end

	assign valid_out = vld_q;
	assign q         = c_q;

endmodule

### hw/rtl/piecewise_linear_time_warp_top.sv
// top level of the two segment piecewise linear time warp
// Maps one Q15.16 timestamp per clock, while the row is not stalled, between source and
// note time bases. A beat accepted on the input channel passes through five front stages
// (capture, segment pick, differences, 34x34 multiply, range check), a row of 36 divider
// cells that each settle one quotient bit, and a rounding and clamping output register.
// One beat is taken every cycle while results drain; the whole row stalls only while a
// finished result waits at the output.
// Configuration writes are taken in any cycle and may be followed by a beat in the
// next one.
module piecewise_linear_time_warp_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pwtw_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pwtw_pkg::TIME_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic signed [pwtw_pkg::TIME_W-1:0] time_value,
	input  logic [pwtw_pkg::SC_W-1:0]    file_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [pwtw_pkg::TIME_W-1:0] mapped_time,
	output logic                         saturated,
	output logic                         midpoint_used
);
	import pwtw_pkg::*;

	cfg_t cfg;
	logic en;

	pwtw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// capture
	logic                     v_s0;
	logic                     kind_s0;
	logic signed [TIME_W-1:0] t_s0;
	logic        [SC_W-1:0]   flen_s0;

	// segment pick
	logic                     v_s1;
	logic signed [SEG_W-1:0]  t_s1, x1_s1, x2_s1, y1_s1, y2_s1;
	logic signed [SEG_W-1:0]  t33, cend, tail, sc33, rl33, lb33;
	logic signed [SEG_W-1:0]  x1_n, x2_n, y1_n, y2_n;

	assign t33  = SEG_W'(t_s0);
	assign lb33 = SEG_W'(cfg.lead_gap);
	assign cend = lb33 + SEG_W'(cfg.cons_len);
	assign tail = $signed({2'b00, flen_s0}) - SEG_W'(cfg.tail_gap);
	assign sc33 = $signed({2'b00, cfg.stretched});
	assign rl33 = SEG_W'(cfg.note_len);

	always_comb begin
		if (kind_s0) begin
			if (t33 <= sc33) begin
				x1_n = '0;   x2_n = sc33; y1_n = lb33; y2_n = cend;
			end else begin
				x1_n = sc33; x2_n = rl33; y1_n = cend; y2_n = tail;
			end
		end else begin
			if (t33 <= cend) begin
				x1_n = lb33; x2_n = cend; y1_n = '0;   y2_n = sc33;
			end else begin
				x1_n = cend; x2_n = tail; y1_n = sc33; y2_n = rl33;
			end
		end
	end

	// differences
	logic                    v_s2;
	logic        [MAG_W-1:0] adt_s2, ady_s2, adx_s2;
	logic signed [MAG_W-1:0] base_s2;
	logic                    neg_s2, mid_s2;
	logic signed [MAG_W-1:0] dt, dy, dx, ysum;

	assign dt   = MAG_W'(t_s1) - MAG_W'(x1_s1);
	assign dy   = MAG_W'(y2_s1) - MAG_W'(y1_s1);
	assign dx   = MAG_W'(x2_s1) - MAG_W'(x1_s1);
	assign ysum = MAG_W'(y1_s1) + MAG_W'(y2_s1);

	// multiply
	logic                    v_s3;
	logic        [PROD_W-1:0] prod_s3;
	logic        [MAG_W-1:0] dvs_s3;
	logic signed [MAG_W-1:0] base_s3;
	logic                    neg_s3, mid_s3;

	// range check into the cell row
	logic  v_s4;
	cell_t c_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s0 <= kind;
			t_s0    <= time_value;
			flen_s0 <= file_length;

			t_s1  <= t33;
			x1_s1 <= x1_n;
			x2_s1 <= x2_n;
			y1_s1 <= y1_n;
			y2_s1 <= y2_n;

			adt_s2  <= dt[MAG_W-1] ? MAG_W'(-dt) : dt;
			ady_s2  <= dy[MAG_W-1] ? MAG_W'(-dy) : dy;
			adx_s2  <= dx[MAG_W-1] ? MAG_W'(-dx) : dx;
			neg_s2  <= (dt[MAG_W-1] ^ dy[MAG_W-1]) ^ dx[MAG_W-1];
			mid_s2  <= (x1_s1 == x2_s1);
			base_s2 <= (x1_s1 == x2_s1) ? (ysum >>> 1) : MAG_W'(y1_s1);

			prod_s3 <= PROD_W'(adt_s2) * PROD_W'(ady_s2);
			dvs_s3  <= adx_s2;
			base_s3 <= base_s2;
			neg_s3  <= neg_s2;
			mid_s3  <= mid_s2;

			c_s4.ovf   <= MAG_W'(prod_s3[PROD_W-1:QBITS]) >= dvs_s3;
			c_s4.rem   <= MAG_W'(prod_s3[PROD_W-1:QBITS]);
			c_s4.pbits <= prod_s3[QBITS-1:0];
			c_s4.quo   <= '0;
			c_s4.dvs   <= dvs_s3;
			c_s4.base  <= base_s3;
			c_s4.neg   <= neg_s3;
			c_s4.mid   <= mid_s3;
		end
	end

	// divider row
	cell_t chain   [QBITS+1];
	logic  chain_v [QBITS+1];

	assign chain[0]   = c_s4;
	assign chain_v[0] = v_s4;

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		pwtw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (chain_v[i]),
			.d         (chain[i]),
			.valid_out (chain_v[i+1]),
			.q         (chain[i+1])
		);
	end

	// rounding and clamping
	cell_t                   fin;
	logic                    rnd;
	logic        [QBITS:0]   qr;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] tmax, tmin;
	logic signed [TIME_W-1:0] res_n;
	logic                    sat_n;

	assign fin  = chain[QBITS];
	assign tmax = SUM_W'({1'b0, {(TIME_W-1){1'b1}}});
	assign tmin = SUM_W'($signed({1'b1, {(TIME_W-1){1'b0}}}));

	always_comb begin
		rnd = {fin.rem, 1'b0} >= {1'b0, fin.dvs};
		qr  = {1'b0, fin.quo} + (QBITS+1)'(rnd);
		if (fin.mid) begin
			sum = SUM_W'(fin.base);
		end else if (fin.neg) begin
			sum = SUM_W'(fin.base) - $signed({1'b0, qr});
		end else begin
			sum = SUM_W'(fin.base) + $signed({1'b0, qr});
		end
		if (!fin.mid && fin.ovf) begin
			sat_n = 1'b1;
			res_n = fin.neg ? TIME_W'(tmin) : TIME_W'(tmax);
		end else if (sum > tmax) begin
			sat_n = 1'b1;
			res_n = TIME_W'(tmax);
		end else if (sum < tmin) begin
			sat_n = 1'b1;
			res_n = TIME_W'(tmin);
		end else begin
			sat_n = 1'b0;
			res_n = TIME_W'(sum);
		end
	end

	logic signed [TIME_W-1:0] mapped_q;
	logic                     sat_q, mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_v[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mapped_q <= res_n;
			sat_q    <= sat_n;
			mid_q    <= fin.mid;
		end
	end

	assign out_valid     = out_valid_q;
	assign mapped_time   = mapped_q;
	assign saturated     = sat_q;
	assign midpoint_used = mid_q;

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (mapped_time == TIME_W'(tmax) || mapped_time == TIME_W'(tmin)))
		else $error("saturated beat not at a range limit");
	a_out_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(chain_v[QBITS]))
		else $error("result beat without a finished item");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

### tb/piecewise_linear_time_warp_top_test.sv
// self-checking testbench for the piecewise linear time warp top level
module piecewise_linear_time_warp_top_test;
	import pwtw_pkg::*;

	typedef struct {
		logic [31:0] mapped;
		logic        sat;
		logic        mid;
	} warp_res_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [TIME_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic signed [TIME_W-1:0] time_value;
	logic [SC_W-1:0]   file_length;
	logic              out_valid;
	logic              out_ready;
	logic signed [TIME_W-1:0] mapped_time;
	logic              saturated;
	logic              midpoint_used;

	piecewise_linear_time_warp_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.time_value(time_value), .file_length(file_length),
		.out_valid(out_valid), .out_ready(out_ready), .mapped_time(mapped_time),
		.saturated(saturated), .midpoint_used(midpoint_used)
	);

	// predictor copy of the configuration
	longint lblank, cons, rblank, req_len, vel, stretch_c;
	warp_res_t pending_q[$];
	int errors, mismatches, beats_in, beats_out, sats_seen, mids_seen;
	int send_idle_pct, recv_stall_pct;
	longint cycles;
	localparam longint CYCLE_LIMIT = 400000;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void restretch();
		longint e;
		longint unsigned v;
		e = 1 - vel;
		if (cons <= 0) begin
			stretch_c = 0;
			return;
		end
		if (e >= 0) v = (e >= 40) ? 64'h7FFFFFFF : longint'(cons) << e;
		else v = (-e >= 63) ? 0 : longint'(cons) >> (-e);
		if (v > 64'h7FFFFFFF) v = 64'h7FFFFFFF;
		stretch_c = longint'(v);
	endfunction

	function automatic warp_res_t interp(longint t, longint x1, longint x2,
			longint y1, longint y2);
		warp_res_t res;
		longint r, s;
		logic signed [127:0] num, q, rm, ad, dt, dy, dx;
		res.sat = 0;
		res.mid = 0;
		if (x1 == x2) begin
			s = y1 + y2;
			res.mid = 1;
			r = s >>> 1;
		end else begin
			dt = t - x1;
			dy = y2 - y1;
			dx = x2 - x1;
			num = dt * dy;
			ad = dx < 0 ? -dx : dx;
			if (num < 0) begin
				q = (-num) / ad;
				rm = (-num) % ad;
			end else begin
				q = num / ad;
				rm = num % ad;
			end
			if (2 * rm >= ad) q = q + 1;
			if ((num < 0) != (dx < 0)) q = -q;
			if (q > 128'sh7FFFFFFF + 128'sh7FFFFFFFFF || q < -128'sh7FFFFFFFFF) begin
				res.sat = 1;
				res.mapped = q < 0 ? 32'h80000000 : 32'h7FFFFFFF;
				return res;
			end
			r = y1 + longint'(q);
		end
		if (r > 64'sh7FFFFFFF) begin
			res.sat = 1;
			r = 64'sh7FFFFFFF;
		end else if (r < -64'sh80000000) begin
			res.sat = 1;
			r = -64'sh80000000;
		end
		res.mapped = r[31:0];
		return res;
	endfunction

	function automatic warp_res_t predict_warp(logic k, logic [31:0] tv, logic [30:0] fl);
		longint t, cend, tail;
		t = longint'(signed'(tv));
		cend = lblank + cons;
		tail = longint'({1'b0, fl}) - rblank;
		if (k) begin
			if (t <= stretch_c) return interp(t, 0, stretch_c, lblank, cend);
			return interp(t, stretch_c, req_len, cend, tail);
		end
		if (t <= cend) return interp(t, lblank, cend, 0, stretch_c);
		return interp(t, cend, tail, stretch_c, req_len);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_LEFT_BLANK:    lblank = longint'(signed'(val));
			REG_CONSONANT_LEN: cons = longint'(signed'(val));
			REG_RIGHT_BLANK:   rblank = longint'(signed'(val));
			REG_REQUIRED_LEN:  req_len = longint'(signed'(val));
			REG_NOTE_VELOCITY: vel = longint'(signed'(val[4:0]));
			default: ;
		endcase
		restretch();
	endtask

	task automatic set_config(logic [31:0] lb, logic [31:0] cl, logic [31:0] rb,
			logic [31:0] rl, logic [4:0] v);
		write_reg(REG_LEFT_BLANK, lb);
		write_reg(REG_CONSONANT_LEN, cl);
		write_reg(REG_RIGHT_BLANK, rb);
		write_reg(REG_REQUIRED_LEN, rl);
		write_reg(REG_NOTE_VELOCITY, {27'(0), v});
		cfg_valid <= 0;
	endtask

	task automatic send_beat(logic k, logic [31:0] tv, logic [30:0] fl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		time_value <= tv;
		file_length <= fl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_q.push_back(predict_warp(k, tv, fl));
		beats_in++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			warp_res_t e;
			beats_out++;
			if (pending_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %h", mapped_time);
			end else begin
				e = pending_q.pop_front();
				sats_seen += e.sat;
				mids_seen += e.mid;
				if (e.mapped !== mapped_time || e.sat !== saturated
						|| e.mid !== midpoint_used) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp %h sat %b mid %b, got %h sat %b mid %b",
							e.mapped, e.sat, e.mid, mapped_time, saturated, midpoint_used);
				end
			end
		end
	end

	function automatic logic [31:0] rand_time();
		case ($urandom_range(5))
			0: return 32'h80000000 + $urandom_range(3);
			1: return 32'h7FFFFFFF - $urandom_range(3);
			2: return $urandom;
			default: return 32'(signed'($urandom_range(0, 32'h00200000)) - 32'sh00080000);
		endcase
	endfunction

	task automatic random_items(int n);
		repeat (n)
			send_beat($urandom_range(1), rand_time(),
				$urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h00180000)));
	endtask

	task automatic random_config();
		set_config($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00020000),
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00030000),
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00020000),
			$urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00040000),
			$urandom_range(7) == 0 ? 5'($urandom) : 5'(signed'($urandom_range(12)) - 4));
	endtask

	task automatic test_reset_defaults();
		send_beat(0, 32'h00010000, 31'h00020000);
		send_beat(1, 32'hFFFF0000, 31'h0);
		drain();
	endtask

	task automatic test_directed();
		set_config(32'h00001000, 32'h00008000, 32'h00002000, 32'h00030000, 5'd0);
		send_beat(0, 32'h00000000, 31'h00040000);
		send_beat(0, 32'h00001000, 31'h00040000);
		send_beat(0, 32'h00009000, 31'h00040000);
		send_beat(0, 32'h00020000, 31'h7FFFFFFF);
		send_beat(1, 32'h00010000, 31'h00040000);
		send_beat(1, 32'h00030000, 31'h00040000);
		send_beat(1, 32'h80000000, 31'h0);
		send_beat(0, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_beat(0, 32'hAAAAAAAA, 31'h55555555);
		send_beat(1, 32'h55555555, 31'h2AAAAAAA);
		drain();
		// extremes: zero width segments, huge slopes, odd velocities
		set_config(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 5'd8);
		send_beat(0, 32'h00000000, 31'h7FFFFFFF);
		send_beat(1, 32'h7FFFFFFF, 31'h0);
		send_beat(1, 32'h80000000, 31'h7FFFFFFF);
		drain();
		set_config(32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000, 5'h1C);
		send_beat(0, 32'h7FFFFFFF, 31'h0);
		send_beat(1, 32'h0, 31'h7FFFFFFF);
		send_beat(1, 32'h00000001, 31'h1);
		drain();
		set_config(32'h0, 32'h40000000, 32'h0, 32'h0, 5'h0F);
		send_beat(0, 32'h20000000, 31'h12345678);
		send_beat(1, 32'h0, 31'h0);
		drain();
		set_config(32'h0, 32'hFFFF0000, 32'h0, 32'h00010000, 5'h10);
		send_beat(0, 32'hFFFF8000, 31'h00010000);
		send_beat(1, 32'h00008000, 31'h00010000);
		drain();
	endtask

	task automatic test_random_phase(int idle, int stall, int n);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (4) begin
			random_config();
			random_items(n / 4);
			drain();
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		kind = 0;
		time_value = '0;
		file_length = '0;
		out_ready = 0;
		cycles = 0;
		errors = 0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		sats_seen = 0;
		mids_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		lblank = 0;
		cons = 0;
		rblank = 0;
		req_len = 0;
		vel = 1;
		stretch_c = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_phase(0, 0, 500);
		test_random_phase(59, 0, 500);
		test_random_phase(0, 59, 500);
		test_random_phase(24, 24, 500);
		drain();
		if (pending_q.size() != 0) errors++;
		$display("mapped %0d timestamps in both directions, %0d results back", beats_in,
			beats_out);
		$display("clamped results %0d, zero width segments %0d", sats_seen, mids_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
